@@ hdl/aabb_frustum_visibility_test_unit_assert.svh @@
// Assertion macros used by the frustum visibility test plane cell RTL.
`ifndef AABB_FRUSTUM_VISIBILITY_TEST_UNIT_ASSERT_SVH
`define AABB_FRUSTUM_VISIBILITY_TEST_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked only outside reset.
`define ASSERT_SYNC(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ASSERT_SYNC(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ hdl/afvt_pkg.sv @@
// Shared constants and types of the frustum visibility test unit.
`default_nettype none
package afvt_pkg;

   localparam int NUM_PLANES          = 6;
   localparam int PLANE_W             = 64;
   localparam int FIELD_W             = 16;
   localparam int D_ALIGN             = 14;
   localparam int CSR_IDX_W           = 3;
   localparam int COORD_WIDTH_DEFAULT = 16;

   // Control that travels with each box through the cell chain.
   typedef struct packed {
      logic valid;
      logic visible;
   } afvt_flow_type;

endpackage
`default_nettype wire

@@ hdl/afvt_cell.sv @@
// One plane cell: holds a plane, tests the passing box, hands it to the next cell.
`default_nettype none
`include "aabb_frustum_visibility_test_unit_assert.svh"
module afvt_cell import afvt_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       cfg_we,
   input  logic [PLANE_W-1:0]         cfg_data,
   input  logic [6*COORD_WIDTH-1:0]   box_in,
   input  afvt_flow_type              flow_in,
   output logic [6*COORD_WIDTH-1:0]   box_out,
   output afvt_flow_type              flow_out
);

   localparam int BOX_W  = 6 * COORD_WIDTH;
   localparam int PROD_W = FIELD_W + COORD_WIDTH;
   localparam int BASE_W = (PROD_W > FIELD_W + D_ALIGN) ? PROD_W : FIELD_W + D_ALIGN;
   localparam int SUM_W  = BASE_W + 2;

   logic [PLANE_W-1:0]             plane_ff;
   logic [PLANE_W-1:0]             plane_in;

   logic signed [FIELD_W-1:0]      normal [3];
   logic signed [COORD_WIDTH-1:0]  vertex [3];
   logic signed [PROD_W-1:0]       prod_in [3];
   logic signed [PROD_W-1:0]       prod_ff [3];
   logic [BOX_W-1:0]               s1_box_ff;
   afvt_flow_type                  s1_flow_ff;

   logic signed [FIELD_W-1:0]      d_term;
   logic signed [SUM_W-1:0]        plane_dist;
   logic [BOX_W-1:0]               box_ff;
   afvt_flow_type                  flow_ff;
   afvt_flow_type                  flow_in_s2;
   logic                           s1_culled;

   assign plane_in = cfg_we ? cfg_data : plane_ff;

   // Positive vertex per axis: max corner unless the normal is negative.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         normal[a]  = $signed(plane_ff[a*FIELD_W +: FIELD_W]);
         vertex[a]  = normal[a][FIELD_W-1] ? $signed(box_in[a*COORD_WIDTH +: COORD_WIDTH])
                                           : $signed(box_in[(a+3)*COORD_WIDTH +: COORD_WIDTH]);
         prod_in[a] = PROD_W'(normal[a]) * PROD_W'(vertex[a]);
      end
   end

   assign d_term = $signed(plane_ff[3*FIELD_W +: FIELD_W]);

   // Exact distance: three products plus d aligned to the product scale.
   always_comb begin
      plane_dist = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2])
                 + (SUM_W'(d_term) <<< D_ALIGN);
      flow_in_s2.valid   = s1_flow_ff.valid;
      flow_in_s2.visible = s1_flow_ff.visible & ~plane_dist[SUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff         <= '0;
         s1_flow_ff.valid <= 1'b0;
         flow_ff.valid    <= 1'b0;
      end else begin
         plane_ff <= plane_in;
         if (advance) begin
            s1_flow_ff <= flow_in;
            s1_box_ff  <= box_in;
            prod_ff    <= prod_in;
            flow_ff    <= flow_in_s2;
            box_ff     <= s1_box_ff;
         end
      end
   end

   assign box_out  = box_ff;
   assign flow_out = flow_ff;

   assign s1_culled = s1_flow_ff.valid & ~s1_flow_ff.visible;

   `ASSERT_SYNC(a_cull_sticky, clock, reset, advance && s1_culled |=> !flow_ff.visible)
   `ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !s1_flow_ff.valid && !flow_ff.valid)
   `ASSERT_SYNC(a_hold_on_stall, clock, reset, !advance |=> $stable(flow_ff) && $stable(s1_flow_ff))

endmodule
`default_nettype wire

@@ hdl/aabb_frustum_visibility_test_unit.sv @@
// Top level of the frustum visibility test unit: a row of six plane cells.
//
// Usage:
//   Write the six planes through the csr_ channel (index 0..5: left, right,
//   bottom, top, near, far; nx, ny, nz Q1.14 in bits 47:0, d Q7.8 in 63:48)
//   while no box is in flight. csr_ready is always high; other indexes drop.
//   Send boxes on req_ (min and max corners, signed, 8 fraction bits). One
//   beat goes in per clock while req_stall is low, back to back.
//   Each box passes through six plane cells, two register stages per cell;
//   the first stage loads at the accepting edge; one result per box, in order.
//   rsp_visible is 0 when some plane puts the box entirely on its negative side.
//   Throughput is one box per cycle, set by the cell chain advancing as a
//   whole. When rsp_stall holds a waiting result, the whole chain holds and
//   req_stall rises; a bubble in the chain never blocks the input.
//   Reset clears all planes to zero (every box visible) and empties the
//   chain. No clearing pass is needed.
`default_nettype none
module aabb_frustum_visibility_test_unit import afvt_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_min_x,
   input  logic signed [COORD_WIDTH-1:0] req_min_y,
   input  logic signed [COORD_WIDTH-1:0] req_min_z,
   input  logic signed [COORD_WIDTH-1:0] req_max_x,
   input  logic signed [COORD_WIDTH-1:0] req_max_y,
   input  logic signed [COORD_WIDTH-1:0] req_max_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_visible,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [PLANE_W-1:0]            csr_data
);

   localparam int BOX_W = 6 * COORD_WIDTH;

   logic [BOX_W-1:0] box_chain  [NUM_PLANES+1];
   afvt_flow_type    flow_chain [NUM_PLANES+1];
   logic             advance;

   // Advance unless the result register is full and stalled.
   assign advance   = ~(flow_chain[NUM_PLANES].valid & rsp_stall);
   assign req_stall = ~advance;
   assign csr_ready = 1'b1;

   assign box_chain[0] = {req_max_z, req_max_y, req_max_x, req_min_z, req_min_y, req_min_x};
   assign flow_chain[0].valid   = req_valid;
   assign flow_chain[0].visible = 1'b1;

   for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
      afvt_cell #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cfg_we   (csr_valid && (csr_index == CSR_IDX_W'(g))),
         .cfg_data (csr_data),
         .box_in   (box_chain[g]),
         .flow_in  (flow_chain[g]),
         .box_out  (box_chain[g+1]),
         .flow_out (flow_chain[g+1])
      );
   end

   assign rsp_valid   = flow_chain[NUM_PLANES].valid;
   assign rsp_visible = flow_chain[NUM_PLANES].visible;

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the frustum visibility test unit.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import afvt_pkg::*;

   localparam int CW         = COORD_WIDTH_DEFAULT;
   localparam int LONG_HOLD  = 300;
   localparam int PHASES     = 8;
   localparam int PHASE_BOXES = 225;

   typedef enum logic [CSR_IDX_W-1:0] {
      PLANE_LEFT, PLANE_RIGHT, PLANE_BOTTOM, PLANE_TOP, PLANE_NEAR, PLANE_FAR,
      IDX_SPARE6, IDX_SPARE7
   } csr_index_e;

   // Axis 0 is x, 1 is y, 2 is z.
   typedef struct packed {
      logic [2:0][CW-1:0] hi;
      logic [2:0][CW-1:0] lo;
   } box_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic signed [CW-1:0]   req_min_x = '0;
   logic signed [CW-1:0]   req_min_y = '0;
   logic signed [CW-1:0]   req_min_z = '0;
   logic signed [CW-1:0]   req_max_x = '0;
   logic signed [CW-1:0]   req_max_y = '0;
   logic signed [CW-1:0]   req_max_z = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_visible;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [PLANE_W-1:0]     csr_data = '0;

   logic [PLANE_W-1:0] plane_cfg [NUM_PLANES];
   box_t               pending_boxes [$];
   logic               expected_visible [$];
   box_t               offered_box;
   int                 boxes_outstanding = 0;
   int                 mismatches = 0;
   int unsigned        tx_gap_left = 0;
   int unsigned        rx_gap_left = 0;
   bit                 idling_on = 1'b1;
   bit                 rx_hold_go = 1'b0;
   logic               rx_hold = 1'b0;

   aabb_frustum_visibility_test_unit #(.COORD_WIDTH(CW)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_min_x   (req_min_x),
      .req_min_y   (req_min_y),
      .req_min_z   (req_min_z),
      .req_max_x   (req_max_x),
      .req_max_y   (req_max_y),
      .req_max_z   (req_max_z),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_visible (rsp_visible),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   // Visible unless some plane puts the positive vertex on its negative side.
   function automatic logic visible_for(box_t b);
      longint  plane_dist;
      shortint n;
      shortint d_q78;
      logic    vis;
      vis = 1'b1;
      for (int p = 0; p < NUM_PLANES; p++) begin
         d_q78 = plane_cfg[p][FIELD_W*3 +: FIELD_W];
         plane_dist = longint'(d_q78) * (longint'(1) <<< D_ALIGN);
         for (int a = 0; a < 3; a++) begin
            n = plane_cfg[p][FIELD_W*a +: FIELD_W];
            plane_dist += longint'(n) * longint'($signed(n >= 0 ? b.hi[a] : b.lo[a]));
         end
         if (plane_dist < 0)
            vis = 1'b0;
      end
      return vis;
   endfunction

   function automatic int unsigned idle_len();
      int unsigned r;
      if (!idling_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic box_t make_box(int lx, int ly, int lz, int hx, int hy, int hz);
      box_t b;
      b.lo[0] = lx[CW-1:0];
      b.lo[1] = ly[CW-1:0];
      b.lo[2] = lz[CW-1:0];
      b.hi[0] = hx[CW-1:0];
      b.hi[1] = hy[CW-1:0];
      b.hi[2] = hz[CW-1:0];
      return b;
   endfunction

   function automatic logic [PLANE_W-1:0] make_plane(int nx, int ny, int nz, int d);
      return {d[15:0], nz[15:0], ny[15:0], nx[15:0]};
   endfunction

   // Mix zero planes, raw bit patterns and planes with a positive offset so
   // that both outcomes show up often.
   function automatic logic [PLANE_W-1:0] random_plane();
      logic [PLANE_W-1:0] p;
      int unsigned        pick;
      pick = $urandom_range(0, 7);
      if (pick == 0)
         p = '0;
      else if (pick == 1)
         p = {$urandom, $urandom};
      else begin
         p[47:0] = 48'({$urandom, $urandom});
         p[63:48] = FIELD_W'($urandom_range(2048, 32767));
      end
      return p;
   endfunction

   function automatic box_t random_box();
      box_t              b;
      logic [CW-1:0]     u;
      logic [CW-1:0]     v;
      bit                wide;
      wide = ($urandom_range(0, 3) == 0);
      for (int a = 0; a < 3; a++) begin
         if (wide) begin
            u = CW'($urandom);
            v = CW'($urandom);
         end else begin
            u = CW'($urandom_range(0, 2047) - 1024);
            v = u + CW'($urandom_range(0, 255));
         end
         if (!wide && $urandom_range(0, 9) == 0) begin
            b.lo[a] = v;
            b.hi[a] = u;
         end else begin
            b.lo[a] = u;
            b.hi[a] = v;
         end
      end
      return b;
   endfunction

   task automatic write_plane(input csr_index_e idx, input logic [PLANE_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      if (idx < NUM_PLANES)
         plane_cfg[idx] = value;
      csr_valid <= 1'b0;
   endtask

   task automatic send_box(input box_t b);
      pending_boxes.push_back(b);
      boxes_outstanding++;
   endtask

   task automatic wait_drained();
      while (boxes_outstanding != 0)
         @(posedge clock);
   endtask

   // Driver: predict on acceptance, then offer the next box after a gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap_left = 0;
      end else begin
         if (req_valid && !req_stall)
            expected_visible.push_back(visible_for(offered_box));
         if (!req_valid || !req_stall) begin
            if (tx_gap_left != 0) begin
               tx_gap_left--;
               req_valid <= 1'b0;
            end else if (pending_boxes.size() != 0) begin
               offered_box = pending_boxes.pop_front();
               req_valid <= 1'b1;
               req_min_x <= offered_box.lo[0];
               req_min_y <= offered_box.lo[1];
               req_min_z <= offered_box.lo[2];
               req_max_x <= offered_box.hi[0];
               req_max_y <= offered_box.hi[1];
               req_max_z <= offered_box.hi[2];
               tx_gap_left = idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result beat against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_gap_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_visible.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual %0b",
                        $time, rsp_visible);
               mismatches++;
            end else begin
               if (rsp_visible !== expected_visible[0]) begin
                  $display("%0t ns: rsp_visible mismatch, expected %0b, actual %0b",
                           $time, expected_visible[0], rsp_visible);
                  mismatches++;
               end
               void'(expected_visible.pop_front());
               boxes_outstanding--;
            end
         end
         if (rx_hold)
            rsp_stall <= 1'b1;
         else if (rx_gap_left != 0) begin
            rx_gap_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            rx_gap_left = idle_len();
         end
      end
   end

   // Hold the result side off long enough to back the chain up to the input.
   initial begin
      wait (rx_hold_go);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rx_hold <= 1'b0;
   end

   initial begin
      for (int p = 0; p < NUM_PLANES; p++)
         plane_cfg[p] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Planes cleared by reset: everything is visible.
      send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
      send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
      send_box(make_box(0, 0, 0, 0, 0, 0));
      send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
      wait_drained();

      // Axis planes: x >= 0, x <= 10.0, y >= -1.0; spare indexes must drop.
      write_plane(PLANE_LEFT, make_plane(16384, 0, 0, 0));
      write_plane(PLANE_RIGHT, make_plane(-16384, 0, 0, 2560));
      write_plane(PLANE_BOTTOM, make_plane(0, 16384, 0, 256));
      write_plane(PLANE_TOP, '0);
      write_plane(PLANE_NEAR, '0);
      write_plane(PLANE_FAR, '0);
      write_plane(IDX_SPARE6, '1);
      write_plane(IDX_SPARE7, '1);
      send_box(make_box(-100, -100, -100, 0, 0, 0));
      send_box(make_box(-100, 0, 0, -1, 0, 0));
      send_box(make_box(5, 0, 0, -1, 0, 0));
      send_box(make_box(2561, 0, 0, 3000, 0, 0));
      send_box(make_box(2560, 0, 0, 3000, -256, 0));
      send_box(make_box(0, -300, 0, 10, -257, 0));
      wait_drained();

      // Most negative normals and offset everywhere.
      for (int i = 0; i < NUM_PLANES; i++)
         write_plane(csr_index_e'(i), make_plane(-32768, -32768, -32768, -32768));
      send_box(make_box(-32768, -32768, -32768, 0, 0, 0));
      send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
      send_box(make_box(0, 0, 0, 32767, 32767, 32767));
      send_box(make_box(-16384, 0, 0, 0, 0, 0));
      wait_drained();

      // Most positive normals and offset everywhere.
      for (int i = 0; i < NUM_PLANES; i++)
         write_plane(csr_index_e'(i), make_plane(32767, 32767, 32767, 32767));
      send_box(make_box(0, 0, 0, 32767, 32767, 32767));
      send_box(make_box(0, 0, 0, -32768, -32768, -32768));
      send_box(make_box(0, 0, 0, -16384, 0, 0));
      send_box(make_box(0, 0, 0, -16385, 0, 0));
      wait_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         for (int i = 0; i < NUM_PLANES; i++)
            write_plane(csr_index_e'(i), random_plane());
         if ($urandom_range(0, 1) == 1)
            write_plane(csr_index_e'($urandom_range(NUM_PLANES, 7)), {$urandom, $urandom});
         idling_on = !(ph == 0 || ph == 5);
         if (ph == 3)
            rx_hold_go = 1'b1;
         for (int k = 0; k < PHASE_BOXES; k++)
            send_box(random_box());
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_visible.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire

@@ files.f @@
+incdir+hdl
hdl/afvt_pkg.sv
hdl/afvt_cell.sv
hdl/aabb_frustum_visibility_test_unit.sv
tb/testbench.sv
